@@ rtl/core/ryuv_pkg.sv @@
// Shared types and constants of the RGB to YUV 4:2:0 converter.
package ryuv_pkg;

    localparam int CFG_W        = 13;
    localparam int CFG_CMP_W    = CFG_W + 1;
    localparam int COMP_W       = 8;
    localparam int SUM_W        = 10;
    localparam int LUMA_IDX_W   = 24;
    localparam int CHROMA_IDX_W = 22;
    localparam int S_DATA_W     = 24;
    localparam int M_DATA_W     = 72;
    localparam int M_USER_W     = 2;

    // tuser bit positions on the result channel
    localparam int USER_CHROMA_VALID = 0;
    localparam int USER_SIZE_ERROR   = 1;

    // register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic row_odd;
        logic col_odd;
        logic frame_end;
    } pos_flags_t;

endpackage

@@ rtl/core/ryuv_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ryuv_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/ryuv_csc.sv @@
// BT.601 integer colour space conversion of one pixel, clamped to 8 bits.
module ryuv_csc (
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic [7:0] luma,
    output logic [7:0] u_val,
    output logic [7:0] v_val
);

    function automatic logic [7:0] clamp8(input logic signed [17:0] val);
        logic [7:0] res;
        if (val < 0) begin
            res = 8'd0;
        end else if (val > 18'sd255) begin
            res = 8'd255;
        end else begin
            res = val[7:0];
        end
        return res;
    endfunction

    logic signed [17:0] r_s, g_s, b_s;
    logic signed [17:0] y_acc, u_acc, v_acc;
    logic signed [17:0] y_div, u_div, v_div;

    assign r_s = 18'(signed'({1'b0, red}));
    assign g_s = 18'(signed'({1'b0, green}));
    assign b_s = 18'(signed'({1'b0, blue}));

    assign y_acc = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
    assign u_acc = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
    assign v_acc = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;

    // arithmetic shift: floor division by 256
    assign y_div = (y_acc >>> 8) + 18'sd16;
    assign u_div = (u_acc >>> 8) + 18'sd128;
    assign v_div = (v_acc >>> 8) + 18'sd128;

    assign luma  = clamp8(y_div);
    assign u_val = clamp8(u_div);
    assign v_val = clamp8(v_div);

endmodule

@@ rtl/core/ryuv_position.sv @@
// Raster position counters with luma, chroma and line store addressing.
module ryuv_position #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int DEPTH  = MAX_WIDTH / 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [ryuv_pkg::CFG_W-1:0]          frame_width,
    input  logic [ryuv_pkg::CFG_W-1:0]          frame_height,
    output ryuv_pkg::pos_flags_t                flags,
    output logic [ryuv_pkg::LUMA_IDX_W-1:0]     luma_index,
    output logic [ryuv_pkg::CHROMA_IDX_W-1:0]   chroma_index,
    output logic [ADDR_W-1:0]                   store_addr
);

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W   = ryuv_pkg::CFG_CMP_W;
    localparam int LFULL_W = ROW_W + ryuv_pkg::CFG_W + 1;
    localparam int CFULL_W = ROW_W + ryuv_pkg::CFG_W;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               row_wrap, frame_wrap;
    logic [LFULL_W-1:0] luma_full;
    logic [CFULL_W-1:0] chroma_full;

    assign row_wrap   = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(frame_width);
    assign frame_wrap = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(frame_height);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (row_wrap) begin
                col_next = '0;
                row_next = frame_wrap ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign luma_full   = LFULL_W'(row_reg) * LFULL_W'(frame_width) + LFULL_W'(col_reg);
    assign chroma_full = CFULL_W'(row_reg >> 1) * CFULL_W'(frame_width >> 1)
                       + CFULL_W'(col_reg >> 1);

    assign luma_index      = ryuv_pkg::LUMA_IDX_W'(luma_full);
    assign chroma_index    = ryuv_pkg::CHROMA_IDX_W'(chroma_full);
    assign store_addr      = ADDR_W'(col_reg >> 1);
    assign flags.row_odd   = row_reg[0];
    assign flags.col_odd   = col_reg[0];
    assign flags.frame_end = row_wrap && frame_wrap;

endmodule

@@ rtl/core/rgb_to_yuv420_converter_core.sv @@
// Top level of the streaming RGB to YUV 4:2:0 converter.
//
// One RGB pixel per transaction in raster order; one result per pixel, one pixel per clock
// sustained while m_tready accepts; each pixel passes the input register, then the result
// register. Luma goes out on every pixel; the U/V average of a 2x2 block rides on the
// pixel at its odd row and odd column, flagged by tuser bit 0. Block sums live in two
// line RAMs of MAX_WIDTH/2 entries of 10 bits; the RAM read is issued on the even pixel of
// an odd row, so the following odd pixel finds the registered word ready. The RAMs need
// no clearing pass after reset. An odd, too small or too large frame size raises tuser
// bit 1 on every result, with all other fields zero and the position left untouched.
// tlast marks the last pixel of a frame. Change the frame size only while idle.
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_index,
    input  logic [ryuv_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [ryuv_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // luma [7:0], luma_index [31:8], chroma_u [39:32], chroma_v [47:40],
    // chroma_index [69:48], zero [71:70]
    output logic [ryuv_pkg::M_DATA_W-1:0]     m_tdata,
    // chroma_valid [0], size_error [1]
    output logic [ryuv_pkg::M_USER_W-1:0]     m_tuser,
    // frame_end
    output logic                              m_tlast
);

    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = ryuv_pkg::CFG_CMP_W;
    localparam int SUM_W  = ryuv_pkg::SUM_W;

    logic [ryuv_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;

    logic                          in_valid_reg;
    logic [ryuv_pkg::S_DATA_W-1:0] in_data_reg;
    logic                          out_valid_reg;
    logic [ryuv_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic [ryuv_pkg::M_USER_W-1:0] out_user_reg, out_user_next;
    logic                          out_last_reg, out_last_next;
    logic [7:0]                    pair_u_reg, pair_v_reg;

    logic advance, process, size_bad;
    logic [7:0] luma, u_val, v_val;
    ryuv_pkg::pos_flags_t flags;
    logic [ryuv_pkg::LUMA_IDX_W-1:0]   luma_index;
    logic [ryuv_pkg::CHROMA_IDX_W-1:0] chroma_index;
    logic [ADDR_W-1:0]                 store_addr;
    logic             store_wr, store_rd;
    logic [SUM_W-1:0] wr_u, wr_v, rd_u, rd_v, sum_u, sum_v;
    logic [7:0]       chroma_u, chroma_v;
    logic             chroma_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ryuv_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ryuv_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ryuv_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                ryuv_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign size_bad = frame_width_reg[0] || frame_height_reg[0]
                   || (frame_width_reg < ryuv_pkg::CFG_W'(2))
                   || (frame_height_reg < ryuv_pkg::CFG_W'(2))
                   || (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH))
                   || (CMP_W'(frame_height_reg) > CMP_W'(MAX_HEIGHT));

    // move the input register forward whenever the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign process  = advance && !size_bad;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    ryuv_csc u_csc (
        .red   (in_data_reg[7:0]),
        .green (in_data_reg[15:8]),
        .blue  (in_data_reg[23:16]),
        .luma  (luma),
        .u_val (u_val),
        .v_val (v_val)
    );

    ryuv_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (process),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .flags        (flags),
        .luma_index   (luma_index),
        .chroma_index (chroma_index),
        .store_addr   (store_addr)
    );

    // the even pixel of a pair leaves its U/V here for the odd one
    always_ff @(posedge aclk) begin
        if (process && !flags.col_odd) begin
            pair_u_reg <= u_val;
            pair_v_reg <= v_val;
        end
    end

    // the odd row's even pixel only fetches; its share is added on the odd pixel
    assign store_rd = process && flags.row_odd && !flags.col_odd;
    assign store_wr = process && !(flags.row_odd && !flags.col_odd);

    assign sum_u = rd_u + SUM_W'(pair_u_reg) + SUM_W'(u_val);
    assign sum_v = rd_v + SUM_W'(pair_v_reg) + SUM_W'(v_val);

    always_comb begin
        if (!flags.col_odd) begin
            wr_u = SUM_W'(u_val);
            wr_v = SUM_W'(v_val);
        end else if (flags.row_odd) begin
            wr_u = rd_u + SUM_W'(pair_u_reg);
            wr_v = rd_v + SUM_W'(pair_v_reg);
        end else begin
            wr_u = SUM_W'(pair_u_reg) + SUM_W'(u_val);
            wr_v = SUM_W'(pair_v_reg) + SUM_W'(v_val);
        end
    end

    ryuv_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_store_u (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (store_addr),
        .wr_data (wr_u),
        .rd_en   (store_rd),
        .rd_addr (store_addr),
        .rd_data (rd_u)
    );

    ryuv_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_store_v (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (store_addr),
        .wr_data (wr_v),
        .rd_en   (store_rd),
        .rd_addr (store_addr),
        .rd_data (rd_v)
    );

    // rounded average of the four block samples
    assign chroma_u     = 8'((SUM_W'(sum_u) + SUM_W'(2)) >> 2);
    assign chroma_v     = 8'((SUM_W'(sum_v) + SUM_W'(2)) >> 2);
    assign chroma_valid = flags.row_odd && flags.col_odd;

    always_comb begin
        out_data_next = '0;
        out_user_next = '0;
        out_last_next = 1'b0;
        if (size_bad) begin
            out_user_next[ryuv_pkg::USER_SIZE_ERROR] = 1'b1;
        end else begin
            out_data_next[7:0]  = luma;
            out_data_next[31:8] = luma_index;
            if (chroma_valid) begin
                out_data_next[39:32] = chroma_u;
                out_data_next[47:40] = chroma_v;
                out_data_next[69:48] = chroma_index;
                out_user_next[ryuv_pkg::USER_CHROMA_VALID] = 1'b1;
            end
            out_last_next = flags.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_ready_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    a_store_one_port : assert property (@(posedge aclk) disable iff (!aresetn)
        !(store_wr && store_rd))
        else $error("line store read and written by the same pixel");

    a_chroma_on_odd_pair : assert property (@(posedge aclk) disable iff (!aresetn)
        (process && flags.row_odd && flags.col_odd)
        |=> (m_tvalid && m_tuser[ryuv_pkg::USER_CHROMA_VALID]))
        else $error("completed block produced no chroma");

    a_error_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[ryuv_pkg::USER_SIZE_ERROR])
        |-> (!m_tuser[ryuv_pkg::USER_CHROMA_VALID] && !m_tlast))
        else $error("size error result carries chroma or frame end");

endmodule

@@ tb/tb_rgb_to_yuv420_converter_core.sv @@
// Self-checking testbench of the streaming RGB to YUV 4:2:0 converter core.
module tb_rgb_to_yuv420_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int STORE_DEPTH    = MAX_WIDTH / 2;
    localparam int DUT_LATENCY    = 2;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 2000;

    // tdata of the pixel channel, red in the lowest byte
    typedef struct packed {
        logic [ryuv_pkg::COMP_W-1:0] blue;
        logic [ryuv_pkg::COMP_W-1:0] green;
        logic [ryuv_pkg::COMP_W-1:0] red;
    } rgb_pixel_t;

    // tdata of the result channel, luma in the lowest byte
    typedef struct packed {
        logic [1:0]                        pad;
        logic [ryuv_pkg::CHROMA_IDX_W-1:0] chroma_index;
        logic [ryuv_pkg::COMP_W-1:0]       chroma_v;
        logic [ryuv_pkg::COMP_W-1:0]       chroma_u;
        logic [ryuv_pkg::LUMA_IDX_W-1:0]   luma_index;
        logic [ryuv_pkg::COMP_W-1:0]       luma;
    } yuv_word_t;

    typedef struct packed {
        yuv_word_t word;
        logic      chroma_valid;
        logic      size_error;
        logic      frame_end;
    } yuv_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic                            cfg_wr_index;
    logic [ryuv_pkg::CFG_W-1:0]      cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ryuv_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ryuv_pkg::M_DATA_W-1:0]   m_tdata;
    logic [ryuv_pkg::M_USER_W-1:0]   m_tuser;
    logic                            m_tlast;

    // predictor state
    logic [ryuv_pkg::CFG_W-1:0]  frame_w;
    logic [ryuv_pkg::CFG_W-1:0]  frame_h;
    int unsigned                 pix_col;
    int unsigned                 pix_row;
    logic [ryuv_pkg::SUM_W-1:0]  u_store [STORE_DEPTH];
    logic [ryuv_pkg::SUM_W-1:0]  v_store [STORE_DEPTH];

    yuv_result_t pending_yuv [$];
    int          mismatches;
    int          quiet_cycles;
    bit          idling_on;

    rgb_to_yuv420_converter_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) return 8'h00;
        if (v > 255) return 8'hff;
        return v[7:0];
    endfunction

    function automatic logic size_unusable();
        return frame_w[0] || frame_h[0] || frame_w < 2 || frame_h < 2 ||
               frame_w > MAX_WIDTH || frame_h > MAX_HEIGHT;
    endfunction

    function automatic yuv_result_t predict_yuv(input rgb_pixel_t px);
        yuv_result_t res;
        int r, g, b, y, u, v;
        int unsigned slot;
        logic [ryuv_pkg::SUM_W-1:0] su, sv;
        res = '0;
        if (size_unusable()) begin
            // hold position and store
            res.size_error = 1'b1;
            return res;
        end
        r = px.red;
        g = px.green;
        b = px.blue;
        y = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        u = clamp_byte(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
        v = clamp_byte(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
        slot = (pix_col >> 1) % STORE_DEPTH;
        if (pix_row % 2 == 0 && pix_col % 2 == 0) begin
            u_store[slot] = ryuv_pkg::SUM_W'(u);
            v_store[slot] = ryuv_pkg::SUM_W'(v);
        end else if (pix_row % 2 == 0 || pix_col % 2 == 0) begin
            u_store[slot] = u_store[slot] + ryuv_pkg::SUM_W'(u);
            v_store[slot] = v_store[slot] + ryuv_pkg::SUM_W'(v);
        end else begin
            su = u_store[slot] + ryuv_pkg::SUM_W'(u);
            sv = v_store[slot] + ryuv_pkg::SUM_W'(v);
            res.word.chroma_u     = 8'((int'(su) + 2) >> 2);
            res.word.chroma_v     = 8'((int'(sv) + 2) >> 2);
            res.word.chroma_index = ryuv_pkg::CHROMA_IDX_W'((pix_row >> 1) * (frame_w >> 1) +
                                                            (pix_col >> 1));
            res.chroma_valid      = 1'b1;
        end
        res.word.luma       = y[7:0];
        res.word.luma_index = ryuv_pkg::LUMA_IDX_W'(pix_row * frame_w + pix_col);
        // advance position; wrap as soon as the limit is reached or passed
        if (pix_col + 1 >= frame_w) begin
            pix_col = 0;
            if (pix_row + 1 >= frame_h) begin
                pix_row = 0;
                res.frame_end = 1'b1;
            end else begin
                pix_row++;
            end
        end else begin
            pix_col++;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_w = ryuv_pkg::FRAME_WIDTH_RESET;
            frame_h = ryuv_pkg::FRAME_HEIGHT_RESET;
            pix_col = 0;
            pix_row = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == ryuv_pkg::REG_FRAME_WIDTH) begin
                    frame_w = cfg_wr_data;
                end else begin
                    frame_h = cfg_wr_data;
                end
            end
            if (s_tvalid && s_tready) begin
                pending_yuv.push_back(predict_yuv(rgb_pixel_t'(s_tdata)));
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] want, seen);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, seen);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want, seen);
        if (want !== seen) report_mismatch(what, want, seen);
    endtask

    always @(posedge aclk) begin
        yuv_result_t want;
        yuv_word_t   seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (pending_yuv.size() == 0) begin
                report_mismatch("result with nothing expected", 0, seen.luma_index);
            end else begin
                want = pending_yuv.pop_front();
                check_field("luma", want.word.luma, seen.luma);
                check_field("luma_index", want.word.luma_index, seen.luma_index);
                check_field("chroma_u", want.word.chroma_u, seen.chroma_u);
                check_field("chroma_v", want.word.chroma_v, seen.chroma_v);
                check_field("chroma_index", want.word.chroma_index, seen.chroma_index);
                check_field("tdata padding", want.word.pad, seen.pad);
                check_field("chroma_valid", want.chroma_valid,
                            m_tuser[ryuv_pkg::USER_CHROMA_VALID]);
                check_field("size_error", want.size_error,
                            m_tuser[ryuv_pkg::USER_SIZE_ERROR]);
                check_field("frame_end", want.frame_end, m_tlast);
            end
        end
    end

    // end the run when no transaction has happened for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_to_yuv420_converter_core regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // result-side back-pressure in random bursts
    initial begin : sink_pacing
        int run;
        m_tready = 1'b0;
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                run = $urandom_range(1, 13);
                @(negedge aclk);
                m_tready = 1'b0;
            end else begin
                run = $urandom_range(1, 24);
                @(negedge aclk);
                m_tready = 1'b1;
            end
            repeat (run - 1) @(negedge aclk);
        end
    end

    task automatic send_pixel(input rgb_pixel_t px);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t px;
        px = rgb_pixel_t'($urandom);
        if ($urandom_range(0, 7) == 0) px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 7) == 0) px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 7) == 0) px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        return px;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    // drop valid and wait until the core has returned every result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_yuv.size() != 0) @(posedge aclk);
        repeat (DUT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic index, input int unsigned value);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = index;
        cfg_wr_data  = value[ryuv_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
    endtask

    task automatic set_frame_size(input int unsigned width, height);
        drain_results();
        write_reg(ryuv_pkg::REG_FRAME_WIDTH, width);
        write_reg(ryuv_pkg::REG_FRAME_HEIGHT, height);
    endtask

    // pixels left until the frame wraps at the present size; zero at a frame start
    function automatic int pixels_to_frame_end();
        int row_rest, rows_after;
        if (pix_col == 0 && pix_row == 0) return 0;
        row_rest   = (pix_col + 1 >= frame_w) ? 1 : int'(frame_w) - int'(pix_col);
        rows_after = (pix_row + 1 >= frame_h) ? 0 : int'(frame_h) - int'(pix_row) - 1;
        return row_rest + rows_after * int'(frame_w);
    endfunction

    function automatic int unsigned unusable_dim();
        case ($urandom_range(0, 2))
            0:       return 2 * $urandom_range(0, 4095) + 1;
            1:       return 0;
            default: return 2 * $urandom_range(2049, 4095);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'h0000ff);
        send_pixel(24'h00ff00);
    endtask

    // resize while idle inside a frame: width only on an even row
    task automatic test_size_change_mid_frame();
        set_frame_size(8, 4);
        send_random(3);
        drain_results();
        write_reg(ryuv_pkg::REG_FRAME_WIDTH, 2);
        send_random(3);
        drain_results();
        write_reg(ryuv_pkg::REG_FRAME_HEIGHT, 2);
        send_random(pixels_to_frame_end());
    endtask

    task automatic test_colour_extremes();
        logic [23:0] corner [8];
        corner = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00,
                   24'hff0000, 24'h00ffff, 24'hffff00, 24'hff00ff};
        set_frame_size(2, 2);
        foreach (corner[i]) send_pixel(corner[i]);
    endtask

    task automatic test_bad_sizes();
        set_frame_size(3, 2);
        send_random(1);
        set_frame_size(0, 2);
        send_random(1);
        set_frame_size(4098, 2);
        send_random(1);
        set_frame_size(8191, 2);
        send_random(1);
        set_frame_size(2, 1);
        send_random(1);
        set_frame_size(2, 8190);
        send_random(1);
        // position must have been held across the rejected pixels
        set_frame_size(2, 2);
        send_random(4);
    endtask

    // start a row at the widest size, then shrink the width below the current column
    task automatic test_widest_row();
        set_frame_size(MAX_WIDTH, MAX_HEIGHT);
        send_random(64);
        set_frame_size(4, 2);
        send_random(pixels_to_frame_end());
    endtask

    task automatic test_random_frames();
        int sent, count, choice;
        int unsigned width, height;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS - 120) idling_on = 1'b0;
            choice = $urandom_range(0, 9);
            if ($urandom_range(0, 5) == 0) begin
                width  = 2 * $urandom_range(9, 32);
                height = 2;
            end else begin
                width  = 2 * $urandom_range(1, 8);
                height = 2 * $urandom_range(1, 4);
            end
            if (choice == 0) begin
                if ($urandom_range(0, 1)) set_frame_size(unusable_dim(), height);
                else set_frame_size(width, unusable_dim());
                count = $urandom_range(1, 3);
                send_random(count);
            end else if (choice <= 2) begin
                set_frame_size(width, height);
                count = $urandom_range(1, width * height - 1);
                send_random(count);
                drain_results();
                if (pix_row % 2 == 0) begin
                    write_reg(ryuv_pkg::REG_FRAME_WIDTH, 2 * $urandom_range(1, 8));
                end
                write_reg(ryuv_pkg::REG_FRAME_HEIGHT, 2 * $urandom_range(1, 4));
                count += pixels_to_frame_end();
                send_random(pixels_to_frame_end());
            end else begin
                set_frame_size(width, height);
                count = width * height;
                send_random(count);
            end
            sent += count;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = ryuv_pkg::REG_FRAME_WIDTH;
        cfg_wr_data  = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        idling_on    = 1'b1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_size_change_mid_frame();
        test_colour_extremes();
        test_bad_sizes();
        test_widest_row();
        test_random_frames();

        drain_results();
        if (mismatches == 0) begin
            $display("rgb_to_yuv420_converter_core regression: pass");
        end else begin
            $display("rgb_to_yuv420_converter_core regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ryuv_pkg.sv
rtl/core/ryuv_ram.sv
rtl/core/ryuv_csc.sv
rtl/core/ryuv_position.sv
rtl/core/rgb_to_yuv420_converter_core.sv
tb/tb_rgb_to_yuv420_converter_core.sv
